[src/wc_pkg.sv]
// wc_pkg: shared constants for the window centroid block
// default parameter values, fixed field widths and register indexes
// no dependencies
package wc_pkg;

   localparam int DEFAULT_MAX_DIM    = 128;
   localparam int DEFAULT_PIXEL_BITS = 24;
   localparam int DEFAULT_FRAC_BITS  = 8;

   // fixed widths of the register fields, result fields and csr port
   localparam int CFG_BITS      = 8;
   localparam int OUT_BITS      = 16;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;

   localparam logic [CFG_BITS-1:0] RESET_DIM = 8'd100;

   // register index, taken from paddr[2]
   typedef logic reg_index_type;
   localparam reg_index_type REG_WIDTH  = 1'b0;
   localparam reg_index_type REG_HEIGHT = 1'b1;

endpackage

[src/wc_divider.sv]
// wc_divider: restoring divider, one quotient bit per cycle
// computes floor(num * 2^FRAC_BITS / den) for quotients below 2^QUO_BITS
// depends on nothing outside this file
module wc_divider #(
   parameter int NUM_BITS  = 45,
   parameter int DEN_BITS  = 38,
   parameter int FRAC_BITS = 8,
   parameter int QUO_BITS  = 15
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  logic [NUM_BITS-1:0] num,
   input  logic [DEN_BITS-1:0] den,
   output logic                done,
   output logic [QUO_BITS-1:0] quotient
);

   localparam int DVD_BITS = NUM_BITS + FRAC_BITS;
   localparam int CNT_BITS = $clog2(QUO_BITS);

   logic                active_ff, active_in;
   logic                done_ff, done_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [DEN_BITS-1:0] rem_ff, rem_in;
   logic [DEN_BITS-1:0] den_ff, den_in;
   logic [QUO_BITS-1:0] low_ff, low_in;

   logic [DVD_BITS-1:0] dividend;
   logic [DEN_BITS:0]   trial;
   logic                fits;

   assign dividend = DVD_BITS'(num) << FRAC_BITS;
   assign trial    = {rem_ff, low_ff[QUO_BITS-1]};
   assign fits     = trial >= {1'b0, den_ff};

   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      count_in  = count_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      low_in    = low_ff;
      if (load) begin
         // upper part already below den since the quotient fits QUO_BITS
         active_in = 1'b1;
         count_in  = '0;
         rem_in    = DEN_BITS'(dividend >> QUO_BITS);
         den_in    = den;
         low_in    = dividend[QUO_BITS-1:0];
      end else if (active_ff) begin
         rem_in   = fits ? DEN_BITS'(trial - {1'b0, den_ff}) : DEN_BITS'(trial);
         low_in   = {low_ff[QUO_BITS-2:0], fits};
         count_in = count_ff + 1'b1;
         if (count_ff == CNT_BITS'(QUO_BITS - 1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
      count_ff <= count_in;
      rem_ff   <= rem_in;
      den_ff   <= den_in;
      low_ff   <= low_in;
   end

   assign done     = done_ff;
   assign quotient = low_ff;

endmodule

[src/window_centroid_core.sv]
// window_centroid_core: intensity-weighted centroid of a pixel window
// top level; uses wc_pkg and the shared divider wc_divider
//
// usage
//   pixels arrive in raster order on req_pixel_value, one beat per accepted
//   start (start high while busy is low). negative pixels count as zero.
//   while pixels stream and busy is low, a beat is taken every cycle: the sums
//   are updated in the cycle the beat is accepted.
//   after width*height pixels the block raises busy and computes
//   x = column_moment / total and y = row_moment / total with FRAC_BITS
//   fraction bits, one quotient bit per cycle in one shared divider, x first
//   then y. busy stays high up to the result strobe; an empty window answers
//   the centre without a division.
//   the result is shown for one cycle with rsp_valid; it cannot be stalled.
//   the window size is set through the apb port (width at 0x0, height at
//   0x4); a write restarts the current window. write only while idle.
//   reset sets both sizes to 100 and clears the sums and counters.
module window_centroid_core #(
   parameter int MAX_DIM    = wc_pkg::DEFAULT_MAX_DIM,
   parameter int PIXEL_BITS = wc_pkg::DEFAULT_PIXEL_BITS,
   parameter int FRAC_BITS  = wc_pkg::DEFAULT_FRAC_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   // pixel channel
   input  logic                               start,
   output logic                               busy,
   input  logic signed [PIXEL_BITS-1:0]       req_pixel_value,
   // result channel
   output logic                               rsp_valid,
   output logic [wc_pkg::OUT_BITS-1:0]        rsp_centroid_x,
   output logic [wc_pkg::OUT_BITS-1:0]        rsp_centroid_y,
   output logic                               rsp_was_empty,
   // configuration port
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [wc_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [wc_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [wc_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                               pready
);

   localparam int DIM_BITS  = $clog2(MAX_DIM);
   localparam int EFF_BITS  = DIM_BITS + 1;
   localparam int CMP_BITS  = (EFF_BITS > wc_pkg::CFG_BITS) ? EFF_BITS : wc_pkg::CFG_BITS;
   localparam int TOT_BITS  = PIXEL_BITS + 2 * DIM_BITS;
   localparam int MOM_BITS  = TOT_BITS + DIM_BITS;
   localparam int PROD_BITS = PIXEL_BITS + DIM_BITS;
   localparam int QUO_BITS  = DIM_BITS + FRAC_BITS;
   localparam int CEN_BITS  = EFF_BITS + FRAC_BITS;
   localparam int OUT_BITS  = wc_pkg::OUT_BITS;

   typedef enum logic [1:0] {
      ST_ACCUM,
      ST_LOAD,
      ST_DIV_X,
      ST_DIV_Y
   } state_type;

   // size registers
   logic [wc_pkg::CFG_BITS-1:0] width_ff, width_in;
   logic [wc_pkg::CFG_BITS-1:0] height_ff, height_in;

   // accumulation state
   logic [TOT_BITS-1:0] total_ff, total_in;
   logic [MOM_BITS-1:0] col_mom_ff, col_mom_in;
   logic [MOM_BITS-1:0] row_mom_ff, row_mom_in;
   logic [DIM_BITS-1:0] col_ff, col_in;
   logic [DIM_BITS-1:0] row_ff, row_in;

   // sequencer and result registers
   state_type           state_ff, state_in;
   logic [OUT_BITS-1:0] x_hold_ff, x_hold_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [OUT_BITS-1:0] rsp_x_ff, rsp_x_in;
   logic [OUT_BITS-1:0] rsp_y_ff, rsp_y_in;
   logic                rsp_empty_ff, rsp_empty_in;

   logic                csr_write;
   wc_pkg::reg_index_type csr_index;
   logic                accept;
   logic [PIXEL_BITS-1:0] pix;
   logic [PROD_BITS-1:0]  col_prod;
   logic [PROD_BITS-1:0]  row_prod;
   logic [EFF_BITS-1:0]   w_eff;
   logic [EFF_BITS-1:0]   h_eff;
   logic                  col_last;
   logic                  row_last;
   logic [CEN_BITS-1:0]   cen_x;
   logic [CEN_BITS-1:0]   cen_y;

   logic                div_load;
   logic [MOM_BITS-1:0] div_num;
   logic                div_done;
   logic [QUO_BITS-1:0] div_quo;

   // zero counts as one, anything above MAX_DIM counts as MAX_DIM
   function automatic logic [EFF_BITS-1:0] eff_dim(input logic [wc_pkg::CFG_BITS-1:0] v);
      logic [CMP_BITS-1:0] vx;
      vx = CMP_BITS'(v);
      if (v == '0) begin
         return EFF_BITS'(1);
      end else if (vx > CMP_BITS'(MAX_DIM)) begin
         return EFF_BITS'(MAX_DIM);
      end else begin
         return EFF_BITS'(vx);
      end
   endfunction

   // ---------------------------------------------------------------
   // csr port: single wait-free apb slave
   // ---------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[2];

   always_comb begin
      unique case (csr_index)
         wc_pkg::REG_WIDTH:  prdata = wc_pkg::CSR_DATA_BITS'(width_ff);
         wc_pkg::REG_HEIGHT: prdata = wc_pkg::CSR_DATA_BITS'(height_ff);
         default:            prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------
   // pixel datapath
   // ---------------------------------------------------------------
   assign busy   = (state_ff != ST_ACCUM);
   assign accept = start && !busy;

   // clamp negatives to zero
   assign pix = req_pixel_value[PIXEL_BITS-1] ? '0 : req_pixel_value;

   // narrow weights: pixel times a column or row index
   assign col_prod = PROD_BITS'(pix) * PROD_BITS'(col_ff);
   assign row_prod = PROD_BITS'(pix) * PROD_BITS'(row_ff);

   assign w_eff    = eff_dim(width_ff);
   assign h_eff    = eff_dim(height_ff);
   assign col_last = (EFF_BITS'(col_ff) + EFF_BITS'(1)) >= w_eff;
   assign row_last = (EFF_BITS'(row_ff) + EFF_BITS'(1)) >= h_eff;

   // centre of the window for an empty result, truncated half
   assign cen_x = (CEN_BITS'(w_eff) << FRAC_BITS) >> 1;
   assign cen_y = (CEN_BITS'(h_eff) << FRAC_BITS) >> 1;

   // divider takes x first, then y; the total is the divisor for both
   assign div_num = (state_ff == ST_LOAD) ? col_mom_ff : row_mom_ff;

   // ---------------------------------------------------------------
   // sequencer: accumulate, then for a lit window two divisions in the shared divider
   // ---------------------------------------------------------------
   always_comb begin
      width_in     = width_ff;
      height_in    = height_ff;
      total_in     = total_ff;
      col_mom_in   = col_mom_ff;
      row_mom_in   = row_mom_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      state_in     = state_ff;
      x_hold_in    = x_hold_ff;
      rsp_valid_in = 1'b0;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_empty_in = rsp_empty_ff;
      div_load     = 1'b0;

      unique case (state_ff)
         ST_ACCUM: begin
            if (accept) begin
               total_in   = total_ff + TOT_BITS'(pix);
               col_mom_in = col_mom_ff + MOM_BITS'(col_prod);
               row_mom_in = row_mom_ff + MOM_BITS'(row_prod);
               if (!col_last) begin
                  col_in = col_ff + 1'b1;
               end else begin
                  col_in = '0;
                  if (!row_last) begin
                     row_in = row_ff + 1'b1;
                  end else begin
                     // last pixel of the window: sums are final next cycle
                     state_in = ST_LOAD;
                  end
               end
            end
         end
         ST_LOAD: begin
            if (total_ff == '0) begin
               // empty window: report the centre, no division
               rsp_valid_in = 1'b1;
               rsp_x_in     = OUT_BITS'(cen_x);
               rsp_y_in     = OUT_BITS'(cen_y);
               rsp_empty_in = 1'b1;
               total_in     = '0;
               col_mom_in   = '0;
               row_mom_in   = '0;
               row_in       = '0;
               state_in     = ST_ACCUM;
            end else begin
               div_load = 1'b1;
               state_in = ST_DIV_X;
            end
         end
         ST_DIV_X: begin
            if (div_done) begin
               x_hold_in = OUT_BITS'(div_quo);
               div_load  = 1'b1;
               state_in  = ST_DIV_Y;
            end
         end
         ST_DIV_Y: begin
            if (div_done) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = x_hold_ff;
               rsp_y_in     = OUT_BITS'(div_quo);
               rsp_empty_in = 1'b0;
               total_in     = '0;
               col_mom_in   = '0;
               row_mom_in   = '0;
               row_in       = '0;
               state_in     = ST_ACCUM;
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase

      // a size write restarts the window
      if (csr_write) begin
         unique case (csr_index)
            wc_pkg::REG_WIDTH:  width_in  = pwdata[wc_pkg::CFG_BITS-1:0];
            wc_pkg::REG_HEIGHT: height_in = pwdata[wc_pkg::CFG_BITS-1:0];
            default:            width_in  = width_ff;
         endcase
         total_in   = '0;
         col_mom_in = '0;
         row_mom_in = '0;
         col_in     = '0;
         row_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCUM;
         rsp_valid_ff <= 1'b0;
         width_ff     <= wc_pkg::RESET_DIM;
         height_ff    <= wc_pkg::RESET_DIM;
         total_ff     <= '0;
         col_mom_ff   <= '0;
         row_mom_ff   <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         total_ff     <= total_in;
         col_mom_ff   <= col_mom_in;
         row_mom_ff   <= row_mom_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
      end
      x_hold_ff    <= x_hold_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   // shared divider, one quotient bit per cycle
   wc_divider #(
      .NUM_BITS  (MOM_BITS),
      .DEN_BITS  (TOT_BITS),
      .FRAC_BITS (FRAC_BITS),
      .QUO_BITS  (QUO_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .load     (div_load),
      .num      (div_num),
      .den      (total_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_centroid_x = rsp_x_ff;
   assign rsp_centroid_y = rsp_y_ff;
   assign rsp_was_empty  = rsp_empty_ff;

endmodule

[src/wc_checker.sv]
// wc_checker: port-level assertions for window_centroid_core
// depends on wc_pkg; bound to the top level at the end of this file
module wc_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               start,
   input logic                               busy,
   input logic                               rsp_valid,
   input logic                               psel,
   input logic                               penable,
   input logic                               pwrite,
   input logic [wc_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input logic [wc_pkg::CSR_DATA_BITS-1:0]   pwdata,
   input logic [wc_pkg::CSR_DATA_BITS-1:0]   prdata
);

   // reset leaves the block idle with no result pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_valid))
      else $error("block not idle after reset");

   // busy only rises after an accepted beat
   a_busy_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without an accepted beat");

   // a result always comes out of the busy phase
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without a preceding busy phase");

   // never two result strobes in a row
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // a size write reads back masked to the register width
   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      (psel && penable && pwrite) |=>
         ((paddr != $past(paddr)) ||
          (prdata == ($past(pwdata) & wc_pkg::CSR_DATA_BITS'(8'hFF)))))
      else $error("size register read back differs from the write");

endmodule

bind window_centroid_core wc_checker u_wc_checker (.*);

[tb/sv/tb_window_centroid_core.sv]
`timescale 1ns / 1ps
// tb_window_centroid_core: self-checking bench for window_centroid_core
// streams pixel windows of many sizes through the block and checks each centroid
// against an in-bench accumulator model; depends on wc_pkg and the block's rtl
module tb_window_centroid_core;

   localparam int MAX_DIM    = wc_pkg::DEFAULT_MAX_DIM;
   localparam int PIXEL_BITS = wc_pkg::DEFAULT_PIXEL_BITS;
   localparam int FRAC_BITS  = wc_pkg::DEFAULT_FRAC_BITS;

   localparam int CFG_BITS      = wc_pkg::CFG_BITS;
   localparam int OUT_BITS      = wc_pkg::OUT_BITS;
   localparam int CSR_ADDR_BITS = wc_pkg::CSR_ADDR_BITS;
   localparam int CSR_DATA_BITS = wc_pkg::CSR_DATA_BITS;

   // block latency from the last pixel to the result strobe, plus some margin
   localparam int SETTLE_CYCLES = 2 * ($clog2(MAX_DIM) + FRAC_BITS) + 3 + 8;
   localparam int MAX_GAP       = 14;
   localparam int PIXEL_TARGET  = 1400;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int REPORT_LIMIT  = 10;

   typedef logic [PIXEL_BITS-1:0] pixel_type;

   typedef struct packed {
      logic [OUT_BITS-1:0] x;
      logic [OUT_BITS-1:0] y;
      logic                was_empty;
   } centroid_type;

   // content styles for one random window
   typedef enum int {
      WIN_RANDOM,
      WIN_MIXED,
      WIN_DARK,
      WIN_SPARSE,
      WIN_NOISE
   } window_kind_type;

   // ---------------------------------------------------------------
   // clock, reset and block connections
   // ---------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                          start = 1'b0;
   logic                          busy;
   logic signed [PIXEL_BITS-1:0]  req_pixel_value = '0;
   logic                          rsp_valid;
   logic [OUT_BITS-1:0]           rsp_centroid_x;
   logic [OUT_BITS-1:0]           rsp_centroid_y;
   logic                          rsp_was_empty;
   logic                          psel = 1'b0;
   logic                          penable = 1'b0;
   logic                          pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0]      paddr = '0;
   logic [CSR_DATA_BITS-1:0]      pwdata = '0;
   logic [CSR_DATA_BITS-1:0]      prdata;
   logic                          pready;

   always #10 clock = ~clock;

   window_centroid_core #(
      .MAX_DIM   (MAX_DIM),
      .PIXEL_BITS(PIXEL_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_pixel_value(req_pixel_value),
      .rsp_valid      (rsp_valid),
      .rsp_centroid_x (rsp_centroid_x),
      .rsp_centroid_y (rsp_centroid_y),
      .rsp_was_empty  (rsp_was_empty),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   // ---------------------------------------------------------------
   // centroid model: window size registers and running sums
   // ---------------------------------------------------------------
   logic [CFG_BITS-1:0] model_width;
   logic [CFG_BITS-1:0] model_height;
   logic [63:0]         sum_intensity;
   logic [63:0]         sum_col_moment;
   logic [63:0]         sum_row_moment;
   int unsigned         col_pos;
   int unsigned         row_pos;

   centroid_type centroid_expected_q[$];
   pixel_type    pixel_pending_q[$];

   int unsigned pixels_queued = 0;
   int unsigned mismatch_count = 0;
   int unsigned gap_limit = MAX_GAP;
   int unsigned cycle_count = 0;

   // zero acts as one, anything past MAX_DIM saturates
   function automatic int unsigned effective_dim(input logic [CFG_BITS-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return 32'(v);
   endfunction

   function automatic void clear_window();
      sum_intensity  = '0;
      sum_col_moment = '0;
      sum_row_moment = '0;
      col_pos        = 0;
      row_pos        = 0;
   endfunction

   // one accepted pixel beat; queues a centroid when the window closes
   function automatic void accumulate_pixel(input pixel_type raw);
      logic [63:0]  level;
      int unsigned  w;
      int unsigned  h;
      centroid_type c;
      // negative pixels count as dark
      level = raw[PIXEL_BITS-1] ? 64'd0 : 64'(raw);
      w = effective_dim(model_width);
      h = effective_dim(model_height);
      sum_intensity  += level;
      sum_col_moment += level * 64'(col_pos);
      sum_row_moment += level * 64'(row_pos);
      if (col_pos + 1 < w) begin
         col_pos++;
         return;
      end
      col_pos = 0;
      if (row_pos + 1 < h) begin
         row_pos++;
         return;
      end
      if (sum_intensity == 0) begin
         // nothing lit: report the window centre
         c.x         = OUT_BITS'((64'(w) << FRAC_BITS) / 2);
         c.y         = OUT_BITS'((64'(h) << FRAC_BITS) / 2);
         c.was_empty = 1'b1;
      end else begin
         // moments stay below 2^45, so the scaled quotient fits in 64 bits
         c.x         = OUT_BITS'((sum_col_moment << FRAC_BITS) / sum_intensity);
         c.y         = OUT_BITS'((sum_row_moment << FRAC_BITS) / sum_intensity);
         c.was_empty = 1'b0;
      end
      centroid_expected_q.insert(centroid_expected_q.size(), c);
      clear_window();
   endfunction

   function automatic void note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) $display("mismatch: %s", msg);
   endfunction

   // ---------------------------------------------------------------
   // pixel driver: feeds beats from the pending queue with random gaps
   // ---------------------------------------------------------------
   int unsigned gap_left = 0;
   bit          drain_hold = 1'b0;

   always @(posedge clock) begin
      int unsigned results_before;
      logic        next_start;
      pixel_type   next_pixel;
      if (reset) begin
         start           <= 1'b0;
         req_pixel_value <= '0;
         gap_left        = 0;
         drain_hold      = 1'b0;
      end else begin
         next_start = 1'b0;
         // junk on the pixel bus while start is low
         next_pixel = pixel_type'($urandom);
         if (start && !busy) begin
            results_before = centroid_expected_q.size();
            accumulate_pixel(req_pixel_value);
            gap_left = $urandom_range(0, gap_limit);
            // now and then hold the stream until every open result is back
            if (centroid_expected_q.size() > results_before && $urandom_range(0, 7) == 0)
               drain_hold = 1'b1;
         end
         if (drain_hold && centroid_expected_q.size() == 0) drain_hold = 1'b0;
         if (start && busy) begin
            // beat not taken yet: hold it steady
            next_start = 1'b1;
            next_pixel = req_pixel_value;
         end else if (gap_left > 0) begin
            gap_left--;
         end else if (!drain_hold && pixel_pending_q.size() != 0) begin
            next_start = 1'b1;
            next_pixel = pixel_pending_q.pop_front();
         end
         start           <= next_start;
         req_pixel_value <= next_pixel;
      end
   end

   // ---------------------------------------------------------------
   // result monitor: every strobe is matched against the oldest centroid
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      centroid_type want;
      if (!reset && rsp_valid) begin
         if (centroid_expected_q.size() == 0) begin
            note_mismatch($sformatf("unexpected result beat x=%0d y=%0d was_empty=%0d",
                                    rsp_centroid_x, rsp_centroid_y, rsp_was_empty));
         end else begin
            want = centroid_expected_q.pop_front();
            if (rsp_centroid_x !== want.x)
               note_mismatch($sformatf("centroid_x expected %0d, got %0d",
                                       want.x, rsp_centroid_x));
            if (rsp_centroid_y !== want.y)
               note_mismatch($sformatf("centroid_y expected %0d, got %0d",
                                       want.y, rsp_centroid_y));
            if (rsp_was_empty !== want.was_empty)
               note_mismatch($sformatf("was_empty expected %0d, got %0d",
                                       want.was_empty, rsp_was_empty));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // apb register access and stimulus helpers
   // ---------------------------------------------------------------
   // setup cycle, access cycle; pready is tied high so the access ends at once
   task automatic csr_access(input wc_pkg::reg_index_type index, input logic do_write,
                             input logic [CSR_DATA_BITS-1:0] data,
                             output logic [CSR_DATA_BITS-1:0] rdata);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= do_write;
      paddr   <= {index, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // upper data bits are junk, only the low byte lands in the register
   task automatic write_size(input wc_pkg::reg_index_type index,
                             input logic [CFG_BITS-1:0] value);
      logic [CSR_DATA_BITS-1:0] data;
      logic [CSR_DATA_BITS-1:0] unused;
      data = $urandom;
      data[CFG_BITS-1:0] = value;
      csr_access(index, 1'b1, data, unused);
      if (index == wc_pkg::REG_WIDTH) model_width = value;
      else model_height = value;
      // any size write restarts the window
      clear_window();
   endtask

   task automatic check_size(input wc_pkg::reg_index_type index);
      logic [CSR_DATA_BITS-1:0] rdata;
      logic [CSR_DATA_BITS-1:0] want;
      want = CSR_DATA_BITS'(index == wc_pkg::REG_WIDTH ? model_width : model_height);
      csr_access(index, 1'b0, '0, rdata);
      if (rdata !== want)
         note_mismatch($sformatf("readback of register %0d expected %0d, got %0d",
                                 index, want, rdata));
   endtask

   task automatic queue_pixel(input pixel_type value);
      pixel_pending_q.insert(pixel_pending_q.size(), value);
      pixels_queued++;
   endtask

   // non-negative pixel with a random magnitude so high and low sum bits both move
   function automatic pixel_type lit_pixel();
      int unsigned bits;
      bits = $urandom_range(1, PIXEL_BITS - 1);
      return pixel_type'($urandom) & ((pixel_type'(1) << bits) - pixel_type'(1));
   endfunction

   // zero or negative, both of which count as dark
   function automatic pixel_type dark_pixel();
      if ($urandom_range(0, 3) == 0) return '0;
      return pixel_type'($urandom) | (pixel_type'(1) << (PIXEL_BITS - 1));
   endfunction

   task automatic queue_window(input int unsigned cells);
      window_kind_type kind;
      int unsigned     bright;
      // plain lit windows weighted up
      kind = ($urandom_range(0, 2) == 0) ? WIN_RANDOM
                                         : window_kind_type'($urandom_range(0, 4));
      bright = $urandom_range(0, cells - 1);
      for (int unsigned i = 0; i < cells; i++) begin
         case (kind)
            WIN_RANDOM: begin
               queue_pixel(lit_pixel());
            end
            WIN_MIXED: begin
               queue_pixel($urandom_range(0, 1) ? dark_pixel() : lit_pixel());
            end
            WIN_DARK: begin
               queue_pixel(dark_pixel());
            end
            WIN_SPARSE: begin
               queue_pixel(i == bright ? lit_pixel() : pixel_type'(0));
            end
            default: begin
               queue_pixel(pixel_type'($urandom));
            end
         endcase
      end
   endtask

   function automatic logic [CFG_BITS-1:0] extreme_dim();
      case ($urandom_range(0, 2))
         0: return CFG_BITS'(MAX_DIM);
         1: return '1;
         default: return CFG_BITS'($urandom_range(MAX_DIM + 1, 254));
      endcase
   endfunction

   // wait until the stream is drained and all centroids are back,
   // then let the divider settle in case a partial window is still open
   task automatic wait_idle();
      while (pixel_pending_q.size() != 0 || start || centroid_expected_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------
   initial begin
      int unsigned                w;
      int unsigned                h;
      int unsigned                cells;
      int unsigned                windows;
      logic [CFG_BITS-1:0]        new_width;
      logic [CFG_BITS-1:0]        new_height;
      model_width  = wc_pkg::RESET_DIM;
      model_height = wc_pkg::RESET_DIM;
      clear_window();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset sizes read back as 100
      check_size(wc_pkg::REG_WIDTH);
      check_size(wc_pkg::REG_HEIGHT);

      // a few pixels into a default 100x100 window; the size write below
      // has to throw them away
      gap_limit = 3;
      for (int i = 0; i < 5; i++) queue_pixel(lit_pixel());
      wait_idle();

      // zero sizes act as 1x1: every pixel is its own window
      write_size(wc_pkg::REG_WIDTH, '0);
      write_size(wc_pkg::REG_HEIGHT, '0);
      check_size(wc_pkg::REG_WIDTH);
      check_size(wc_pkg::REG_HEIGHT);
      queue_pixel('0);                                      // empty, centre of 1x1
      queue_pixel('1);                                      // -1 clamps to dark
      queue_pixel(pixel_type'(1) << (PIXEL_BITS - 1));      // most negative
      queue_pixel(~(pixel_type'(1) << (PIXEL_BITS - 1)));   // most positive
      queue_pixel(pixel_type'(1));
      queue_pixel(pixel_type'(24'h555555));
      queue_pixel(pixel_type'(24'h2aaaaa));
      wait_idle();

      // 3x2 with a fractional centroid and a clamped negative, then an all-dark 3x2
      write_size(wc_pkg::REG_WIDTH, CFG_BITS'(3));
      write_size(wc_pkg::REG_HEIGHT, CFG_BITS'(2));
      queue_pixel(pixel_type'(10));
      queue_pixel('0);
      queue_pixel(pixel_type'(30));
      queue_pixel('0);
      queue_pixel(pixel_type'(1) << (PIXEL_BITS - 1));
      queue_pixel(pixel_type'(5));
      queue_pixel('0);
      queue_pixel('1);
      queue_pixel(pixel_type'(1) << (PIXEL_BITS - 1));
      queue_pixel('0);
      queue_pixel(pixel_type'(24'hfffff0));
      queue_pixel('0);
      wait_idle();

      // random phases: new sizes, a burst of windows, sometimes a partial
      // window left open so the next size write has to discard it
      while (pixels_queued < PIXEL_TARGET) begin
         case ($urandom_range(0, 9))
            0: begin
               new_width  = extreme_dim();
               new_height = CFG_BITS'($urandom_range(0, 2));
            end
            1: begin
               new_width  = CFG_BITS'($urandom_range(0, 2));
               new_height = extreme_dim();
            end
            2: begin
               new_width  = CFG_BITS'($urandom_range(9, 20));
               new_height = CFG_BITS'($urandom_range(9, 20));
            end
            default: begin
               new_width  = CFG_BITS'($urandom_range(0, 8));
               new_height = CFG_BITS'($urandom_range(0, 8));
            end
         endcase
         if ($urandom_range(0, 1)) begin
            write_size(wc_pkg::REG_WIDTH, new_width);
            write_size(wc_pkg::REG_HEIGHT, new_height);
         end else begin
            write_size(wc_pkg::REG_HEIGHT, new_height);
            write_size(wc_pkg::REG_WIDTH, new_width);
         end
         check_size(wc_pkg::REG_WIDTH);
         check_size(wc_pkg::REG_HEIGHT);

         // some phases run back to back with no gaps at all
         gap_limit = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
         w = effective_dim(new_width);
         h = effective_dim(new_height);
         cells = w * h;
         windows = (cells >= 60) ? 1 : $urandom_range(1, 120 / cells);
         if (windows > 12) windows = 12;
         for (int unsigned k = 0; k < windows; k++) queue_window(cells);
         if (cells > 1 && $urandom_range(0, 3) == 0)
            for (int unsigned k = $urandom_range(1, cells - 1); k > 0; k--)
               queue_pixel(pixel_type'($urandom));
         wait_idle();
      end

      wait_idle();
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
